/* rtl/htd_pkg.sv */
package htd_pkg;

    // sizes
    localparam int COORD_BITS   = 16;
    localparam int CORDIC_STEPS = 16;
    localparam int FRAC         = 16;
    localparam int ATAN_ENTRIES = 24;
    localparam int CORDIC_N     = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;

    localparam int FIELD_W  = 16;
    localparam int D_W      = COORD_BITS + 1;
    localparam int A_W      = COORD_BITS;
    localparam int CW       = COORD_BITS + FRAC + 3;
    localparam int ZW       = 25;
    localparam int N_W      = 2 * COORD_BITS + 2;
    localparam int SQ_STEPS = COORD_BITS + 1;
    localparam int NCELL    = (CORDIC_N > SQ_STEPS) ? CORDIC_N : SQ_STEPS;
    localparam int IDX_W    = $clog2(NCELL);
    localparam int SIGN_IDX = (COORD_BITS <= FIELD_W) ? COORD_BITS - 1 : FIELD_W - 1;

    localparam int HEAD_W = 9;
    localparam int DIST_W = 17;
    localparam int TURN_W = 8;
    localparam int QUAD_W = 3;
    localparam int CWW    = 11;

    // angle constants, degrees with FRAC fractional bits
    localparam logic signed [ZW-1:0] ANG_RIGHT    = ZW'(90 <<< FRAC);
    localparam logic signed [ZW-1:0] ANG_STRAIGHT = ZW'(180 <<< FRAC);
    localparam logic signed [ZW-1:0] ROUND_HALF   = ZW'(1 <<< (FRAC - 1));

    // whole-degree constants
    localparam logic [HEAD_W-1:0] DEG_FULL  = HEAD_W'(360);
    localparam logic [HEAD_W-1:0] DEG_HALF  = HEAD_W'(180);
    localparam logic [HEAD_W-1:0] DEG_UP    = HEAD_W'(90);
    localparam logic [HEAD_W-1:0] DEG_DOWN  = HEAD_W'(270);
    localparam logic [N_W-1:0]    DIST_MAX  = N_W'((1 << DIST_W) - 1);

    // quadrant codes
    localparam logic [QUAD_W-1:0] QUAD_AXIS = 3'd0;
    localparam logic [QUAD_W-1:0] QUAD_1    = 3'd1;
    localparam logic [QUAD_W-1:0] QUAD_2    = 3'd2;
    localparam logic [QUAD_W-1:0] QUAD_3    = 3'd3;
    localparam logic [QUAD_W-1:0] QUAD_4    = 3'd4;

    // per-item flags that ride along the chain
    typedef struct packed {
        logic              dx_neg;
        logic              dx_zero;
        logic              dy_neg;
        logic              dy_zero;
        logic [HEAD_W-1:0] head;
    } t_meta;

    // what one cell hands to the next
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [ZW-1:0] z;
        logic [N_W-1:0]       rem;
        logic [N_W-1:0]       res;
        t_meta                meta;
    } t_cell_data;

    // atan(2^-i) in degrees, FRAC fractional bits
    function automatic logic signed [ZW-1:0] atan_deg(input int i);
        logic signed [ZW-1:0] v;
        case (i)
            0:       v = ZW'(2949120);
            1:       v = ZW'(1740967);
            2:       v = ZW'(919879);
            3:       v = ZW'(466945);
            4:       v = ZW'(234379);
            5:       v = ZW'(117304);
            6:       v = ZW'(58666);
            7:       v = ZW'(29335);
            8:       v = ZW'(14668);
            9:       v = ZW'(7334);
            10:      v = ZW'(3667);
            11:      v = ZW'(1833);
            12:      v = ZW'(917);
            13:      v = ZW'(458);
            14:      v = ZW'(229);
            15:      v = ZW'(115);
            16:      v = ZW'(57);
            17:      v = ZW'(29);
            18:      v = ZW'(14);
            19:      v = ZW'(7);
            20:      v = ZW'(4);
            21:      v = ZW'(2);
            22:      v = ZW'(1);
            default: v = '0;
        endcase
        return v;
    endfunction

    // coordinate from a 16-bit field: low COORD_BITS bits, two's complement
    function automatic logic signed [D_W-1:0] coord_of(input logic [FIELD_W-1:0] f);
        logic signed [D_W-1:0] c;
        logic                  sgn;
        sgn = (COORD_BITS <= FIELD_W) ? f[SIGN_IDX] : 1'b0;
        for (int i = 0; i < D_W; i++) begin
            c[i] = (i < COORD_BITS && i < FIELD_W) ? f[i % FIELD_W] : sgn;
        end
        return c;
    endfunction

endpackage

/* rtl/htd_front.sv */
module htd_front
    import htd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_en,
    input  logic               i_valid,
    input  logic [FIELD_W-1:0] i_cur_x,
    input  logic [FIELD_W-1:0] i_cur_y,
    input  logic [HEAD_W-1:0]  i_cur_heading,
    input  logic [FIELD_W-1:0] i_dest_x,
    input  logic [FIELD_W-1:0] i_dest_y,
    output logic               o_valid,
    output t_cell_data         o_data
);

    logic                  r_v1;
    logic signed [D_W-1:0] r_dx;
    logic signed [D_W-1:0] r_dy;
    logic [HEAD_W-1:0]     r_head;
    logic                  r_v2;
    t_cell_data            r_data;

    logic signed [D_W-1:0] n_dx;
    logic signed [D_W-1:0] n_dy;
    logic [HEAD_W-1:0]     n_head;
    logic [A_W-1:0]        ax;
    logic [A_W-1:0]        ay;
    logic [N_W-1:0]        sq_x;
    logic [N_W-1:0]        sq_y;
    t_cell_data            n_data;

    // differences and heading reduction
    always_comb begin
        n_dx   = coord_of(i_dest_x) - coord_of(i_cur_x);
        n_dy   = coord_of(i_dest_y) - coord_of(i_cur_y);
        n_head = (i_cur_heading >= DEG_FULL) ? i_cur_heading - DEG_FULL : i_cur_heading;
    end

    // magnitudes, squares and the starting vector
    always_comb begin
        ax   = r_dx[D_W-1] ? A_W'(-r_dx) : A_W'(r_dx);
        ay   = r_dy[D_W-1] ? A_W'(-r_dy) : A_W'(r_dy);
        sq_x = N_W'(ax) * N_W'(ax);
        sq_y = N_W'(ay) * N_W'(ay);
        n_data.x            = CW'(ax) <<< FRAC;
        n_data.y            = CW'(ay) <<< FRAC;
        n_data.z            = '0;
        n_data.rem          = sq_x + sq_y;
        n_data.res          = '0;
        n_data.meta.dx_neg  = r_dx[D_W-1];
        n_data.meta.dx_zero = (r_dx == '0);
        n_data.meta.dy_neg  = r_dy[D_W-1];
        n_data.meta.dy_zero = (r_dy == '0);
        n_data.meta.head    = r_head;
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dx   <= n_dx;
            r_dy   <= n_dy;
            r_head <= n_head;
            r_data <= n_data;
        end
    end

    assign o_valid = r_v2;
    assign o_data  = r_data;

endmodule

/* rtl/htd_cell.sv */
module htd_cell
    import htd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic [IDX_W-1:0] i_idx,
    input  logic             i_valid,
    input  t_cell_data       i_data,
    output logic             o_valid,
    output t_cell_data       o_data
);

    logic       r_valid;
    t_cell_data r_data;
    t_cell_data n_data;

    // one cordic rotation (in the first CORDIC_N cells) and one square-root digit (in the first SQ_STEPS cells)
    always_comb begin
        logic signed [CW-1:0] xs;
        logic signed [CW-1:0] ys;
        logic [N_W-1:0]       bit_v;
        logic [N_W-1:0]       trial;
        int                   sh;
        n_data = i_data;
        xs     = i_data.x >>> i_idx;
        ys     = i_data.y >>> i_idx;
        sh     = 0;
        if (int'(i_idx) < SQ_STEPS) begin
            sh = 2 * (SQ_STEPS - 1 - int'(i_idx));
        end
        bit_v = N_W'(1) << sh;
        trial = i_data.res + bit_v;
        if (int'(i_idx) < CORDIC_N) begin
            if (i_data.y > 0) begin
                n_data.x = i_data.x + ys;
                n_data.y = i_data.y - xs;
                n_data.z = i_data.z + atan_deg(int'(i_idx));
            end else begin
                n_data.x = i_data.x - ys;
                n_data.y = i_data.y + xs;
                n_data.z = i_data.z - atan_deg(int'(i_idx));
            end
        end
        if (int'(i_idx) < SQ_STEPS) begin
            if (i_data.rem >= trial) begin
                n_data.rem = i_data.rem - trial;
                n_data.res = (i_data.res >> 1) + bit_v;
            end else begin
                n_data.res = i_data.res >> 1;
            end
        end
    end

    // valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

/* rtl/htd_back.sv */
module htd_back
    import htd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic              i_valid,
    input  t_cell_data        i_data,
    output logic              o_valid,
    output logic [DIST_W-1:0] o_distance,
    output logic [HEAD_W-1:0] o_target_heading,
    output logic              o_turn_ccw,
    output logic [TURN_W-1:0] o_turn_degrees,
    output logic [QUAD_W-1:0] o_quadrant
);

    // stage 1: rounded angle from +x and rounded distance
    logic              r_v1;
    t_meta             r1_meta;
    logic [HEAD_W-1:0] r1_ang;
    logic [DIST_W-1:0] r1_dist;
    logic [HEAD_W-1:0] n1_ang;
    logic [DIST_W-1:0] n1_dist;

    // stage 2: target heading and quadrant
    logic              r_v2;
    logic              r2_same;
    logic [HEAD_W-1:0] r2_head;
    logic [HEAD_W-1:0] r2_target;
    logic [QUAD_W-1:0] r2_quad;
    logic [DIST_W-1:0] r2_dist;
    logic [HEAD_W-1:0] n2_target;
    logic [QUAD_W-1:0] n2_quad;

    // stage 3: output register with the turn
    logic              r_v3;
    logic [DIST_W-1:0] r3_dist;
    logic [HEAD_W-1:0] r3_target;
    logic              r3_ccw;
    logic [TURN_W-1:0] r3_turn;
    logic [QUAD_W-1:0] r3_quad;
    logic              n3_ccw;
    logic [TURN_W-1:0] n3_turn;

    // clamp, fold into the left half, round half up; distance rounding
    always_comb begin
        logic signed [ZW-1:0] a;
        logic signed [ZW-1:0] t;
        logic [ZW-1:0]        t_rnd;
        logic [N_W-1:0]       d;
        if (i_data.meta.dy_zero || i_data.z < 0) begin
            a = '0;
        end else if (i_data.z > ANG_RIGHT) begin
            a = ANG_RIGHT;
        end else begin
            a = i_data.z;
        end
        t      = i_data.meta.dx_neg ? ANG_STRAIGHT - a : a;
        t_rnd  = ZW'(t + ROUND_HALF);
        n1_ang = t_rnd[FRAC +: HEAD_W];
        d      = (i_data.rem > i_data.res) ? i_data.res + N_W'(1) : i_data.res;
        n1_dist = (d > DIST_MAX) ? DIST_W'(DIST_MAX) : DIST_W'(d);
    end

    // target heading by case
    always_comb begin
        if (r1_meta.dx_zero && r1_meta.dy_zero) begin
            n2_target = r1_meta.head;
            n2_quad   = QUAD_AXIS;
        end else if (r1_meta.dx_zero) begin
            n2_target = r1_meta.dy_neg ? DEG_DOWN : DEG_UP;
            n2_quad   = QUAD_AXIS;
        end else if (!r1_meta.dy_neg) begin
            n2_target = r1_ang;
            n2_quad   = r1_meta.dx_neg ? QUAD_2 : QUAD_1;
        end else begin
            n2_target = (r1_ang == '0) ? '0 : DEG_FULL - r1_ang;
            n2_quad   = r1_meta.dx_neg ? QUAD_3 : QUAD_4;
        end
    end

    // shorter turn
    always_comb begin
        logic signed [CWW-1:0] cw;
        cw = CWW'(r2_head) - CWW'(r2_target);
        if (cw <= 0) begin
            cw = cw + CWW'(DEG_FULL);
        end
        if (r2_same) begin
            n3_ccw  = 1'b0;
            n3_turn = '0;
        end else if (cw < CWW'(DEG_HALF)) begin
            n3_ccw  = 1'b0;
            n3_turn = TURN_W'(cw);
        end else begin
            n3_ccw  = 1'b1;
            n3_turn = TURN_W'(CWW'(DEG_FULL) - cw);
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_meta   <= i_data.meta;
            r1_ang    <= n1_ang;
            r1_dist   <= n1_dist;
            r2_same   <= r1_meta.dx_zero && r1_meta.dy_zero;
            r2_head   <= r1_meta.head;
            r2_target <= n2_target;
            r2_quad   <= n2_quad;
            r2_dist   <= r1_dist;
            r3_dist   <= r2_dist;
            r3_target <= r2_target;
            r3_ccw    <= n3_ccw;
            r3_turn   <= n3_turn;
            r3_quad   <= r2_quad;
        end
    end

    assign o_valid          = r_v3;
    assign o_distance       = r3_dist;
    assign o_target_heading = r3_target;
    assign o_turn_ccw       = r3_ccw;
    assign o_turn_degrees   = r3_turn;
    assign o_quadrant       = r3_quad;

endmodule

/* rtl/heading_turn_and_distance.sv */
// channel  | dir | handshake                | payload
// ---------+-----+--------------------------+------------------------------------------
// request  | in  | i_s_tvalid / o_s_tready  | i_s_tdata: positions and current heading
// result   | out | o_m_tvalid / i_m_tready  | o_m_tdata: distance, heading, turn, quadrant
//
// one item enters per cycle unless a result waits on i_m_tready; an item goes through
// 2 front stages, then the row of 17 cells (one square-root
// digit each, the 16 cordic rotations in the first 16), 3 back stages
// the whole pipeline holds while a result waits on i_m_tready
// i_rst_n (synchronous) clears the valid bits only
module heading_turn_and_distance
    import htd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // cur_x[15:0], cur_y[31:16], cur_heading[40:32], dest_x[56:41], dest_y[72:57], zeros
    input  logic [79:0] i_s_tdata,
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // distance[16:0], target_heading[25:17], turn_ccw[26], turn_degrees[34:27],
    // quadrant[37:35], zeros
    output logic [39:0] o_m_tdata
);

    logic              en;
    logic              w_valid [NCELL+1];
    t_cell_data        w_data  [NCELL+1];
    logic              out_valid;
    logic [DIST_W-1:0] distance;
    logic [HEAD_W-1:0] target_heading;
    logic              turn_ccw;
    logic [TURN_W-1:0] turn_degrees;
    logic [QUAD_W-1:0] quadrant;

    // pipeline moves unless a result is stuck at the output
    assign en         = !out_valid || i_m_tready;
    assign o_s_tready = en;

    htd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_valid       (i_s_tvalid),
        .i_cur_x       (i_s_tdata[15:0]),
        .i_cur_y       (i_s_tdata[31:16]),
        .i_cur_heading (i_s_tdata[40:32]),
        .i_dest_x      (i_s_tdata[56:41]),
        .i_dest_y      (i_s_tdata[72:57]),
        .o_valid       (w_valid[0]),
        .o_data        (w_data[0])
    );

    // row of cells
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        htd_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_idx   (IDX_W'(k)),
            .i_valid (w_valid[k]),
            .i_data  (w_data[k]),
            .o_valid (w_valid[k+1]),
            .o_data  (w_data[k+1])
        );
    end

    htd_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (en),
        .i_valid          (w_valid[NCELL]),
        .i_data           (w_data[NCELL]),
        .o_valid          (out_valid),
        .o_distance       (distance),
        .o_target_heading (target_heading),
        .o_turn_ccw       (turn_ccw),
        .o_turn_degrees   (turn_degrees),
        .o_quadrant       (quadrant)
    );

    // result packing
    assign o_m_tvalid = out_valid;
    assign o_m_tdata  = {2'b00, quadrant, turn_degrees, turn_ccw, target_heading, distance};

endmodule

/* test/heading_turn_and_distance_tb.sv */
module heading_turn_and_distance_tb;
    import htd_pkg::*;

    localparam int HALF_PERIOD    = 5;
    localparam int RESET_CYCLES   = 6;
    localparam int RANDOM_ITEMS   = 1000;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int MAX_REPORTS    = 10;
    localparam int PRESS_HOLD     = 400;
    localparam int ANGLE_ONE      = 65536;
    localparam int DIST_SAT       = 131071;

    // atan(2^-i) in degrees, 16 fractional bits
    localparam longint ATAN_STEP_DEG [24] = '{
        2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
        14668, 7334, 3667, 1833, 917, 458, 229, 115,
        57, 29, 14, 7, 4, 2, 1, 0
    };

    typedef struct {
        logic [16:0] distance;
        logic [8:0]  heading;
        logic        turn_ccw;
        logic [7:0]  turn_deg;
        logic [2:0]  quadrant;
    } t_nav_result;

    // expected navigation answers, kept in request order
    class nav_scoreboard;
        t_nav_result expected_q[$];
        int          failures;
        int          results_seen;

        function new();
            failures     = 0;
            results_seen = 0;
        endfunction

        // rounded integer square root, ties round up
        function longint unsigned rounded_root(longint unsigned n);
            longint unsigned r;
            longint unsigned c;
            r = 0;
            for (int b = 17; b >= 0; b--) begin
                c = r | (64'd1 << b);
                if (c * c <= n) r = c;
            end
            if (n - r * r > r) r++;
            return r;
        endfunction

        // vectoring rotations on the first-quadrant vector
        function longint first_quadrant_angle(longint ax, longint ay);
            longint x, y, z, xs, ys;
            x = ax <<< 16;
            y = ay <<< 16;
            z = 0;
            for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
                xs = x >>> i;
                ys = y >>> i;
                if (y > 0) begin
                    x = x + ys;
                    y = y - xs;
                    z = z + ATAN_STEP_DEG[i];
                end else begin
                    x = x - ys;
                    y = y + xs;
                    z = z - ATAN_STEP_DEG[i];
                end
            end
            if (z < 0) z = 0;
            if (z > 90 * ANGLE_ONE) z = 90 * ANGLE_ONE;
            return z;
        endfunction

        function t_nav_result predict_nav(logic [79:0] req);
            t_nav_result     r;
            logic signed [15:0] cx, cy, tx, ty;
            longint          dx, dy, ax, ay, hdg, tgt, cw, ang, t, rd;
            longint unsigned root;
            cx  = req[15:0];
            cy  = req[31:16];
            hdg = longint'(req[40:32]);
            tx  = req[56:41];
            ty  = req[72:57];
            if (hdg >= 360) hdg -= 360;
            dx = longint'(tx) - longint'(cx);
            dy = longint'(ty) - longint'(cy);
            ax = (dx < 0) ? -dx : dx;
            ay = (dy < 0) ? -dy : dy;

            root       = rounded_root(longint'(ax * ax + ay * ay));
            r.distance = (root > DIST_SAT) ? 17'h1FFFF : root[16:0];
            r.quadrant = QUAD_AXIS;
            r.turn_ccw = 1'b0;
            r.turn_deg = '0;

            if (dx == 0 && dy == 0) begin
                // no move: keep heading, no turn
                tgt = hdg;
            end else begin
                if (dx == 0) begin
                    tgt = (dy > 0) ? 90 : 270;
                end else begin
                    ang = (ay == 0) ? 0 : first_quadrant_angle(ax, ay);
                    t   = (dx > 0) ? ang : 180 * ANGLE_ONE - ang;
                    rd  = (t + ANGLE_ONE / 2) >>> 16;
                    if (dy >= 0) begin
                        tgt        = rd;
                        r.quadrant = (dx > 0) ? QUAD_1 : QUAD_2;
                    end else begin
                        tgt        = (rd == 0) ? 0 : 360 - rd;
                        r.quadrant = (dx > 0) ? QUAD_4 : QUAD_3;
                    end
                end
                // shorter turn, equal headings count as a zero ccw turn
                cw = hdg - tgt;
                if (cw <= 0) cw += 360;
                if (cw < 180) begin
                    r.turn_ccw = 1'b0;
                    r.turn_deg = cw[7:0];
                end else begin
                    r.turn_ccw = 1'b1;
                    r.turn_deg = 8'(360 - cw);
                end
            end
            r.heading = tgt[8:0];
            return r;
        endfunction

        function void note_request(logic [79:0] req);
            expected_q.push_back(predict_nav(req));
        endfunction

        function void check_result(logic [39:0] d);
            t_nav_result want;
            results_seen++;
            if (expected_q.size() == 0) begin
                failures++;
                if (failures <= MAX_REPORTS)
                    $display("unexpected result item: %h", d);
                return;
            end
            want = expected_q.pop_front();
            if (d[16:0] !== want.distance || d[25:17] !== want.heading ||
                d[26] !== want.turn_ccw || d[34:27] !== want.turn_deg ||
                d[37:35] !== want.quadrant) begin
                failures++;
                if (failures <= MAX_REPORTS) begin
                    $display("mismatch: exp dist=%0d hdg=%0d ccw=%0d turn=%0d quad=%0d",
                             want.distance, want.heading, want.turn_ccw, want.turn_deg,
                             want.quadrant);
                    $display("          got dist=%0d hdg=%0d ccw=%0d turn=%0d quad=%0d",
                             d[16:0], d[25:17], d[26], d[34:27], d[37:35]);
                end
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [79:0] i_s_tdata;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [39:0] o_m_tdata;

    nav_scoreboard sb = new();
    int            idle_cycles;
    int            press_count;

    heading_turn_and_distance DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    // clock
    initial i_clk = 1'b0;
    always #HALF_PERIOD i_clk = ~i_clk;

    // handshake monitor and watchdog
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            if (i_s_tvalid && o_s_tready) sb.note_request(i_s_tdata);
            if (o_m_tvalid && i_m_tready) sb.check_result(o_m_tdata);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // result side: random stalls, calm stretches, and long hold-offs
    initial begin
        int hold;
        int cyc;
        int pick;
        hold        = 0;
        cyc         = 0;
        press_count = 0;
        i_m_tready  = 1'b0;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            cyc++;
            if (press_count < 2 && sb.results_seen >= 300 + 400 * press_count) begin
                press_count++;
                hold = PRESS_HOLD;
            end
            if (hold > 0) begin
                i_m_tready <= 1'b0;
                hold--;
            end else if (((cyc / 200) % 3) == 0) begin
                i_m_tready <= 1'b1;
            end else begin
                pick = $urandom_range(0, 99);
                if (pick < 20) begin
                    i_m_tready <= 1'b0;
                    hold = $urandom_range(0, 2);
                end else if (pick < 23) begin
                    i_m_tready <= 1'b0;
                    hold = $urandom_range(10, 40);
                end else begin
                    i_m_tready <= 1'b1;
                end
            end
        end
    end

    function automatic logic [79:0] pack_request(logic [15:0] cx, logic [15:0] cy,
                                                 logic [8:0] hdg, logic [15:0] tx,
                                                 logic [15:0] ty);
        return {7'b0, ty, tx, hdg, cy, cx};
    endfunction

    // gap before an item: mostly none or short, some long, calm blocks
    function automatic int pick_gap(int n);
        int pick;
        if (((n / 50) % 4) == 3) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        if (pick < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [15:0] edge_coord();
        case ($urandom_range(0, 4))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'hFFFF;
            3:       return 16'h0001;
            default: return 16'h0000;
        endcase
    endfunction

    function automatic logic [79:0] random_request();
        logic [15:0] cx, cy, tx, ty;
        logic [8:0]  hdg;
        int          kind;
        cx   = 16'($urandom);
        cy   = 16'($urandom);
        tx   = 16'($urandom);
        ty   = 16'($urandom);
        hdg  = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(360, 511))
                                           : 9'($urandom_range(0, 359));
        kind = $urandom_range(0, 99);
        if (kind < 50) begin
            // fully random
        end else if (kind < 70) begin
            // short hop
            tx = cx + 16'($urandom_range(0, 400)) - 16'd200;
            ty = cy + 16'($urandom_range(0, 400)) - 16'd200;
        end else if (kind < 80) begin
            tx = cx;
        end else if (kind < 88) begin
            ty = cy;
        end else if (kind < 92) begin
            tx = cx;
            ty = cy;
        end else begin
            cx = edge_coord();
            cy = edge_coord();
            tx = edge_coord();
            ty = edge_coord();
        end
        return pack_request(cx, cy, hdg, tx, ty);
    endfunction

    // offer one request after a gap and wait until it is taken
    task automatic send_request(logic [79:0] req, int gap);
        repeat (gap) begin
            @(negedge i_clk);
            i_s_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= req;
        do @(posedge i_clk); while (!o_s_tready);
    endtask

    logic [79:0] directed_q[$];

    initial begin
        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // no move, also with an out-of-range heading
        directed_q.push_back(pack_request(16'd0, 16'd0, 9'd0, 16'd0, 16'd0));
        directed_q.push_back(pack_request(16'd100, -16'sd200, 9'd400, 16'd100, -16'sd200));
        // destinations on the y axis, first with equal headings
        directed_q.push_back(pack_request(16'd0, 16'd0, 9'd90, 16'd0, 16'd500));
        directed_q.push_back(pack_request(16'd10, 16'd10, 9'd0, 16'd10, -16'sd990));
        directed_q.push_back(pack_request(16'd0, 16'd0, 9'd90, 16'd0, -16'sd5));
        // destinations on the x axis
        directed_q.push_back(pack_request(16'd0, 16'd0, 9'd180, 16'd1000, 16'd0));
        directed_q.push_back(pack_request(16'd0, 16'd0, 9'd0, -16'sd1000, 16'd0));
        directed_q.push_back(pack_request(16'd0, 16'd0, 9'd359, 16'd100, 16'd0));
        directed_q.push_back(pack_request(16'd0, 16'd0, 9'd5, 16'h8000, 16'd0));
        // one per quadrant
        directed_q.push_back(pack_request(16'd0, 16'd0, 9'd359, 16'd300, 16'd300));
        directed_q.push_back(pack_request(16'd0, 16'd0, 9'd360, -16'sd300, 16'd400));
        directed_q.push_back(pack_request(16'd0, 16'd0, 9'd511, -16'sd500, -16'sd120));
        directed_q.push_back(pack_request(16'd0, 16'd0, 9'd1, 16'd700, -16'sd50));
        // corner to corner
        directed_q.push_back(pack_request(16'h8000, 16'h8000, 9'd200, 16'h7FFF, 16'h7FFF));
        directed_q.push_back(pack_request(16'h7FFF, 16'h7FFF, 9'd17, 16'h8000, 16'h8000));
        directed_q.push_back(pack_request(16'h8000, 16'h7FFF, 9'd270, 16'h7FFF, 16'h8000));
        directed_q.push_back(pack_request(16'h7FFF, 16'h8000, 9'd300, 16'h8000, 16'h7FFF));
        // unit steps and near-axis angles
        directed_q.push_back(pack_request(16'd5, 16'd5, 9'd45, 16'd6, 16'd5));
        directed_q.push_back(pack_request(16'd5, 16'd5, 9'd225, 16'd4, 16'd4));
        directed_q.push_back(pack_request(16'd0, 16'd0, 9'd0, 16'd30000, -16'sd1));
        directed_q.push_back(pack_request(16'd0, 16'd0, 9'd90, 16'd1, 16'd30000));
        directed_q.push_back(pack_request(16'd0, 16'd0, 9'd256, -16'sd30000, 16'd1));

        foreach (directed_q[i]) send_request(directed_q[i], pick_gap(i));
        for (int n = 0; n < RANDOM_ITEMS; n++) send_request(random_request(), pick_gap(n));

        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (sb.failures == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/htd_pkg.sv
rtl/htd_front.sv
rtl/htd_cell.sv
rtl/htd_back.sv
rtl/heading_turn_and_distance.sv
test/heading_turn_and_distance_tb.sv
